[hdl/tcfr_pkg.sv]
// shared widths, codes and the rule record of the call forward resolver
package tcfr_pkg;

   localparam int MAX_RULES_DEF = 64;
   localparam int EXT_W         = 14;
   localparam int END_W         = EXT_W + 1;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 2;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ANSWER  = 2'd3;

   localparam logic [EXT_W-1:0] LOOP_ANSWER = 14'd9999;

   typedef struct packed {
      logic [EXT_W-1:0] source;
      logic [EXT_W-1:0] win_start;
      logic [END_W-1:0] win_end;
      logic [EXT_W-1:0] target;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

endpackage

[hdl/tcfr_if.sv]
// request and response channel interfaces
interface tcfr_req_if
   import tcfr_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [EXT_W-1:0]  extension;
   logic [EXT_W-1:0]  start_time;
   logic [EXT_W-1:0]  duration;
   logic [EXT_W-1:0]  forward_to;

   modport source (output valid, mode, extension, start_time, duration, forward_to,
                   input ready);
   modport sink   (input valid, mode, extension, start_time, duration, forward_to,
                   output ready);
endinterface

interface tcfr_rsp_if
   import tcfr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [EXT_W-1:0]    rings;
   logic                loop_found;

   modport source (output valid, status, rings, loop_found, input ready);
   modport sink   (input valid, status, rings, loop_found, output ready);
endinterface

[hdl/timed_call_forward_resolver_top.sv]
// timed call forward resolver: rule table in ram, sequential chain walk per query
//
//  channel   dir  beat payload                                    flow
//  req_chan  in   mode, extension, start_time, duration, forward_to  valid/ready
//  rsp_chan  out  status, rings, loop_found                       valid/ready
//
//  clear and add answer straight from idle; a query with an empty table answers without a scan
//  a query scans the ram one rule per cycle, restarting from rule 0 after each hop
//  reset clears the rule count and the response register; the ram needs no clearing
//  a new request is taken in idle while the response register is free or being drained
//  a finished query waits in a holding register while the response side stalls
module timed_call_forward_resolver_top
   import tcfr_pkg::*;
#(
   parameter int MAX_RULES = MAX_RULES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcfr_req_if.sink    req_chan,
   tcfr_rsp_if.source  rsp_chan
);

   localparam int CNT_W  = $clog2(MAX_RULES + 1);
   localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int HOP_W  = $clog2(MAX_RULES + 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff,      state_in;
   logic [CNT_W-1:0]    count_ff,      count_in;
   logic [EXT_W-1:0]    cur_ff,        cur_in;
   logic [EXT_W-1:0]    time_ff,       time_in;
   logic [HOP_W-1:0]    hops_ff,       hops_in;
   logic [CNT_W-1:0]    idx_ff,        idx_in;
   logic                chk_vld_ff,    chk_vld_in;
   logic [CNT_W-1:0]    chk_idx_ff,    chk_idx_in;
   logic [EXT_W-1:0]    res_rings_ff,  res_rings_in;
   logic                res_loop_ff,   res_loop_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [EXT_W-1:0]    rsp_rings_ff,  rsp_rings_in;
   logic                rsp_loop_ff,   rsp_loop_in;

   logic                ram_we;
   rule_type            wr_rule;
   rule_type            rd_rule;
   logic [RULE_W-1:0]   ram_rdata;
   logic                rsp_free;
   logic                req_fire;
   logic                hit;
   logic                stop;
   logic [HOP_W-1:0]    hops_next;

   assign wr_rule.source    = req_chan.extension;
   assign wr_rule.win_start = req_chan.start_time;
   assign wr_rule.win_end   = END_W'(req_chan.start_time) + END_W'(req_chan.duration);
   assign wr_rule.target    = req_chan.forward_to;
   assign rd_rule           = rule_type'(ram_rdata);

   tcfr_ram #(
      .WIDTH (RULE_W),
      .DEPTH (MAX_RULES),
      .AW    (ADDR_W)
   ) u_rules (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (wr_rule),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign hit            = (rd_rule.source == cur_ff) && (rd_rule.win_start <= time_ff) &&
                           (END_W'(time_ff) <= rd_rule.win_end);
   assign hops_next      = hops_ff + HOP_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      time_in       = time_ff;
      hops_in       = hops_ff;
      idx_in        = idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      res_rings_in  = res_rings_ff;
      res_loop_in   = res_loop_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rings_in  = rsp_rings_ff;
      rsp_loop_in   = rsp_loop_ff;
      ram_we        = 1'b0;
      stop          = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_rings_in = '0;
               rsp_loop_in  = 1'b0;
               case (req_chan.mode)
                  MODE_CLEAR: begin
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_CLEARED;
                  end
                  MODE_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(MAX_RULES)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_we        = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STATUS_STORED;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_ANSWER;
                        rsp_rings_in  = req_chan.extension;
                     end else begin
                        cur_in     = req_chan.extension;
                        time_in    = req_chan.start_time;
                        hops_in    = '0;
                        idx_in     = '0;
                        chk_vld_in = 1'b0;
                        state_in   = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff) begin
               if (hit) begin
                  stop       = 1'b1;
                  chk_vld_in = 1'b0;
                  if (hops_next > HOP_W'(MAX_RULES)) begin
                     res_rings_in = LOOP_ANSWER;
                     res_loop_in  = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     hops_in = hops_next;
                     cur_in  = rd_rule.target;
                     idx_in  = '0;
                  end
               end else if (chk_idx_ff == count_ff - CNT_W'(1)) begin
                  stop         = 1'b1;
                  chk_vld_in   = 1'b0;
                  res_rings_in = cur_ff;
                  res_loop_in  = 1'b0;
                  state_in     = ST_DONE;
               end
            end
            if (!stop) begin
               if (idx_ff < count_ff) begin
                  chk_vld_in = 1'b1;
                  chk_idx_in = idx_ff;
                  idx_in     = idx_ff + CNT_W'(1);
               end else begin
                  chk_vld_in = 1'b0;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_ANSWER;
               rsp_rings_in  = res_rings_ff;
               rsp_loop_in   = res_loop_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      time_ff       <= time_in;
      hops_ff       <= hops_in;
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      res_rings_ff  <= res_rings_in;
      res_loop_ff   <= res_loop_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rings_ff  <= rsp_rings_in;
      rsp_loop_ff   <= rsp_loop_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.rings      = rsp_rings_ff;
   assign rsp_chan.loop_found = rsp_loop_ff;

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !ram_we)
      else $error("rule table written while a query walks it");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count beyond table depth");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_vld_ff) |-> (chk_idx_ff < count_ff))
      else $error("checked rule beyond stored rules");

   a_hop_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (hops_ff <= HOP_W'(MAX_RULES)))
      else $error("hop count beyond loop limit");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.mode == MODE_CLEAR) |=> (count_ff == '0))
      else $error("clear left rules in the table");

endmodule

[hdl/tcfr_ram.sv]
// generic single write port ram with registered read
module tcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[dv/tb.sv]
// testbench for the timed call forward resolver: rule table predictor, random chains and stalls
`timescale 1ns / 100ps

module tb;
   import tcfr_pkg::*;

   localparam int RULE_CAP  = MAX_RULES_DEF;
   localparam int EXT_MAX   = (1 << EXT_W) - 1;
   localparam int ITEM_GOAL = 1500;
   localparam int CALM_TAIL = 150;
   localparam int LONG_HOLD = 400;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [EXT_W-1:0]  ext;
      logic [EXT_W-1:0]  start;
      logic [EXT_W-1:0]  dur;
      logic [EXT_W-1:0]  fwd;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [EXT_W-1:0]    rings;
      logic                loop_found;
   } answer_type;

   logic clock;
   logic reset;

   tcfr_req_if req_if ();
   tcfr_rsp_if rsp_if ();

   timed_call_forward_resolver_top #(
      .MAX_RULES(RULE_CAP)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   cmd_type    pending_cmd_q[$];
   answer_type expected_answer_q[$];

   rule_type model_rules[RULE_CAP];
   int       model_rule_cnt = 0;

   int         gen_rule_cnt = 0;
   int         pushed_cnt = 0;
   longint     run_budget = 0;
   longint     cycle_cnt = 0;
   int         mismatch_cnt = 0;
   bit         calm_phase = 0;
   bit         hold_ask = 0;
   bit         hold_taken;
   int         hold_left;
   int         send_gap;
   cmd_type    next_cmd;
   cmd_type    taken_cmd;
   answer_type want;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic answer_type apply_cmd(cmd_type c);
      answer_type       a;
      logic [EXT_W-1:0] cur;
      int               hops;
      int               hit;
      int               k;
      bit               looped;
      bit               done;
      a = '0;
      case (c.mode)
         MODE_CLEAR: begin
            model_rule_cnt = 0;
            a.status = STATUS_CLEARED;
         end
         MODE_ADD: begin
            if (model_rule_cnt >= RULE_CAP) begin
               a.status = STATUS_FULL;
            end else begin
               model_rules[model_rule_cnt].source    = c.ext;
               model_rules[model_rule_cnt].win_start = c.start;
               model_rules[model_rule_cnt].win_end   = {1'b0, c.start} + {1'b0, c.dur};
               model_rules[model_rule_cnt].target    = c.fwd;
               model_rule_cnt++;
               a.status = STATUS_STORED;
            end
         end
         default: begin
            cur = c.ext;
            hops = 0;
            looped = 0;
            done = 0;
            while (!done) begin
               hit = -1;
               for (k = model_rule_cnt - 1; k >= 0; k--)
                  if (model_rules[k].source == cur && model_rules[k].win_start <= c.start &&
                      {1'b0, c.start} <= model_rules[k].win_end)
                     hit = k;
               if (hit < 0) begin
                  done = 1;
               end else begin
                  hops++;
                  if (hops > RULE_CAP) begin
                     looped = 1;
                     done = 1;
                  end else begin
                     cur = model_rules[hit].target;
                  end
               end
            end
            a.status     = STATUS_ANSWER;
            a.rings      = looped ? LOOP_ANSWER : cur;
            a.loop_found = looped;
         end
      endcase
      return a;
   endfunction

   task automatic push_cmd(input logic [MODE_W-1:0] m, input int ext, input int st,
                           input int du, input int fw);
      cmd_type c;
      c.mode  = m;
      c.ext   = ext[EXT_W-1:0];
      c.start = st[EXT_W-1:0];
      c.dur   = du[EXT_W-1:0];
      c.fwd   = fw[EXT_W-1:0];
      pending_cmd_q.insert(pending_cmd_q.size(), c);
      run_budget += (gen_rule_cnt + 2) * (RULE_CAP + 2) + 16;
      if (m == MODE_CLEAR)
         gen_rule_cnt = 0;
      else if (m == MODE_ADD && gen_rule_cnt < RULE_CAP)
         gen_rule_cnt++;
      pushed_cnt++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_cmd_q.size() != 0 || req_if.valid || expected_answer_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic int rand_ext();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, EXT_MAX) : $urandom_range(0, 9999);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap > 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_cmd_q.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            send_gap <= $urandom_range(0, 5);
         end else begin
            next_cmd = pending_cmd_q.pop_front();
            req_if.valid      <= 1'b1;
            req_if.mode       <= next_cmd.mode;
            req_if.extension  <= next_cmd.ext;
            req_if.start_time <= next_cmd.start;
            req_if.duration   <= next_cmd.dur;
            req_if.forward_to <= next_cmd.fwd;
         end
      end
   end

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         taken_cmd.mode  = req_if.mode;
         taken_cmd.ext   = req_if.extension;
         taken_cmd.start = req_if.start_time;
         taken_cmd.dur   = req_if.duration;
         taken_cmd.fwd   = req_if.forward_to;
         expected_answer_q.insert(expected_answer_q.size(), apply_cmd(taken_cmd));
      end
   end

   // response ready with bursts and one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_taken) begin
         rsp_if.ready <= 1'b0;
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= $urandom_range(0, 5);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_answer_q.size() == 0) begin
            $display("%0t unexpected beat: expected none actual status %0d rings %0d loop %0b",
                     $time, rsp_if.status, rsp_if.rings, rsp_if.loop_found);
            mismatch_cnt++;
         end else begin
            want = expected_answer_q.pop_front();
            if (rsp_if.status !== want.status) begin
               $display("%0t status mismatch: expected %0d actual %0d", $time,
                        want.status, rsp_if.status);
               mismatch_cnt++;
            end
            if (rsp_if.rings !== want.rings) begin
               $display("%0t rings mismatch: expected %0d actual %0d", $time,
                        want.rings, rsp_if.rings);
               mismatch_cnt++;
            end
            if (rsp_if.loop_found !== want.loop_found) begin
               $display("%0t loop_found mismatch: expected %0b actual %0b", $time,
                        want.loop_found, rsp_if.loop_found);
               mismatch_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > 3 * run_budget + 20000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [EXT_W-1:0] pool[8];
      logic [MODE_W-1:0] qmode;
      int pool_n;
      int n_rules;
      int n_q;
      int base_t;
      int back;
      int st;
      int du;
      int t;
      int i;
      int j;
      bit big;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = MODE_CLEAR;
      req_if.extension = '0;
      req_if.start_time = '0;
      req_if.duration = '0;
      req_if.forward_to = '0;
      rsp_if.ready = 1'b0;
      run_budget = 2000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      push_cmd(MODE_QUERY, EXT_MAX, EXT_MAX, 0, 0);
      push_cmd(MODE_CLEAR, 0, 0, 0, 0);
      push_cmd(MODE_ADD, 100, 10, 0, 200);
      push_cmd(MODE_QUERY, 100, 10, EXT_MAX, EXT_MAX);
      push_cmd(MODE_QUERY, 100, 9, 0, 0);
      push_cmd(MODE_QUERY, 100, 11, 0, 0);
      push_cmd(MODE_ADD, 100, 0, EXT_MAX, 300);
      push_cmd(MODE_QUERY, 100, 10, 0, 0);
      push_cmd(MODE_QUERY, 100, 20, 0, 0);
      push_cmd(MODE_ADD, EXT_MAX, EXT_MAX, EXT_MAX, 0);
      push_cmd(MODE_QUERY, EXT_MAX, EXT_MAX, 0, 0);
      push_cmd(MODE_ADD, 200, 0, 100, 100);
      push_cmd(MODE_QUERY, 100, 10, 0, 0);
      push_cmd(MODE_SPARE, 200, 50, EXT_MAX, EXT_MAX);
      push_cmd(MODE_ADD, 5, 0, EXT_MAX, 5);
      push_cmd(MODE_QUERY, 5, 0, 0, 0);
      push_cmd(MODE_ADD, 10000, 1, 1, EXT_MAX);
      push_cmd(MODE_QUERY, 10000, 2, 0, 0);
      push_cmd(MODE_QUERY, 10000, 3, 0, 0);
      push_cmd(MODE_CLEAR, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX);
      push_cmd(MODE_QUERY, 100, 10, 0, 0);
      push_cmd(MODE_SPARE, 0, 0, 0, 0);
      wait_drained();

      // full table: straight chain of exactly max hops, then a ring
      push_cmd(MODE_CLEAR, 0, 0, 0, 0);
      for (i = 0; i < RULE_CAP; i++)
         push_cmd(MODE_ADD, 2000 + i, 0, EXT_MAX, 2000 + i + 1);
      push_cmd(MODE_QUERY, 2000, 7777, 0, 0);
      push_cmd(MODE_ADD, 1, 1, 1, 1);
      push_cmd(MODE_ADD, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX);
      push_cmd(MODE_QUERY, 2000 + RULE_CAP - 1, 0, 0, 0);
      push_cmd(MODE_CLEAR, 0, 0, 0, 0);
      for (i = 0; i < RULE_CAP; i++)
         push_cmd(MODE_ADD, 3000 + i, 100, 50, 3000 + (i + 1) % RULE_CAP);
      push_cmd(MODE_QUERY, 3000, 150, 0, 0);
      push_cmd(MODE_QUERY, 3000, 151, 0, 0);
      wait_drained();

      // back-pressure: response side holds while requests keep coming
      hold_ask = 1'b1;
      run_budget += LONG_HOLD;
      push_cmd(MODE_CLEAR, 0, 0, 0, 0);
      for (i = 0; i < 40; i++) begin
         if (i % 3 == 2)
            push_cmd(MODE_QUERY, $urandom_range(0, 3), $urandom_range(0, 20), 0, 0);
         else if (gen_rule_cnt < 8)
            push_cmd(MODE_ADD, $urandom_range(0, 3), $urandom_range(0, 10),
                     $urandom_range(0, 10), $urandom_range(0, 3));
         else
            push_cmd(MODE_CLEAR, 0, 0, 0, 0);
      end
      wait_drained();

      while (pushed_cnt < ITEM_GOAL) begin
         if (!calm_phase && pushed_cnt >= ITEM_GOAL - CALM_TAIL) begin
            wait_drained();
            calm_phase = 1'b1;
         end
         big = ($urandom_range(0, 24) == 0);
         if (big || gen_rule_cnt > 10 || $urandom_range(0, 4) != 0)
            push_cmd(MODE_CLEAR, rand_ext(), rand_ext(), rand_ext(), rand_ext());
         n_rules = big ? $urandom_range(RULE_CAP - 8, RULE_CAP + 4) : $urandom_range(0, 6);
         pool_n = $urandom_range(1, 6);
         for (j = 0; j < pool_n; j++)
            pool[j] = rand_ext();
         base_t = rand_ext();
         for (i = 0; i < n_rules; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               push_cmd(MODE_ADD, $urandom_range(0, EXT_MAX), $urandom_range(0, EXT_MAX),
                        $urandom_range(0, EXT_MAX), $urandom_range(0, EXT_MAX));
            end else begin
               back = $urandom_range(0, 40);
               st = (base_t > back) ? base_t - back : 0;
               case ($urandom_range(0, 7))
                  0:       du = 0;
                  1:       du = EXT_MAX;
                  default: du = $urandom_range(0, 100);
               endcase
               push_cmd(MODE_ADD, pool[$urandom_range(0, pool_n - 1)], st, du,
                        ($urandom_range(0, 7) == 0) ? rand_ext() :
                                                      pool[$urandom_range(0, pool_n - 1)]);
            end
         end
         n_q = big ? 2 : $urandom_range(1, 5);
         for (i = 0; i < n_q; i++) begin
            qmode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : MODE_QUERY;
            if ($urandom_range(0, 9) == 0) begin
               push_cmd(qmode, $urandom_range(0, EXT_MAX), $urandom_range(0, EXT_MAX),
                        $urandom_range(0, EXT_MAX), $urandom_range(0, EXT_MAX));
            end else begin
               t = base_t + $urandom_range(0, 80) - 30;
               if (t < 0)
                  t = 0;
               if (t > EXT_MAX)
                  t = EXT_MAX;
               push_cmd(qmode, pool[$urandom_range(0, pool_n - 1)], t,
                        $urandom_range(0, EXT_MAX), $urandom_range(0, EXT_MAX));
            end
         end
         if ($urandom_range(0, 14) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (50) @(negedge clock);
      if (mismatch_cnt == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
